// ===== design/iir_filter_transposed_df2_defines.svh =====
// Assertion macros used by the checker file.
`ifndef IIR_FILTER_TRANSPOSED_DF2_DEFINES_SVH
`define IIR_FILTER_TRANSPOSED_DF2_DEFINES_SVH

// Consequent checked in the cycle after the antecedent, ignored during reset.
`define IIR_TDF2_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// Consequent checked in the same cycle as the antecedent, ignored during reset.
`define IIR_TDF2_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked on the cycle that follows a reset cycle.
`define IIR_TDF2_ASSERT_RESET(lbl, clk, rstn, cons, msg) \
    lbl: assert property (@(posedge clk) (!rstn) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/iir_tdf2_pkg.sv =====
package iir_tdf2_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int COEF_W     = 24;
    localparam int STATE_W    = 48;
    localparam int ACC_W      = 50;
    localparam int FRAC_BITS  = 20;
    localparam int ORDER_W    = 2;
    localparam int COEF_PAIRS = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int STEP_W     = 3;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [STATE_W-1:0]  state_t;
    typedef logic signed [ACC_W-1:0]    acc_t;
    typedef logic [COEF_PAIRS:1][COEF_W-1:0] coef_bank_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORDER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_B0    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B1    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B2    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_B3    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_A1    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_A2    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_A3    = 3'd7;

    localparam coef_t  COEF_ONE   = 24'sh100000;
    localparam sample_t SAMPLE_MAX = 24'sh7FFFFF;
    localparam sample_t SAMPLE_MIN = 24'sh800000;
    localparam state_t STATE_MAX  = 48'sh7FFF_FFFF_FFFF;
    localparam state_t STATE_MIN  = 48'sh8000_0000_0000;
    localparam acc_t   ROUND_HALF = acc_t'(1) <<< (FRAC_BITS - 1);

    // Program steps
    localparam logic [STEP_W-1:0] ST_IDLE    = 3'd0;
    localparam logic [STEP_W-1:0] ST_MUL_B0  = 3'd1;
    localparam logic [STEP_W-1:0] ST_SUM_D0  = 3'd2;
    localparam logic [STEP_W-1:0] ST_OUT     = 3'd3;
    localparam logic [STEP_W-1:0] ST_TAP_BX  = 3'd4;
    localparam logic [STEP_W-1:0] ST_TAP_AY  = 3'd5;
    localparam logic [STEP_W-1:0] ST_TAP_SUB = 3'd6;
    localparam logic [STEP_W-1:0] ST_TAP_WR  = 3'd7;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD_D,
        ACC_PROD_D,
        ACC_ADD_P,
        ACC_SUB_P
    } acc_op_t;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_WAIT_IN,
        JMP_WAIT_OUT,
        JMP_LOOP
    } jmp_t;

    typedef struct packed {
        logic              take_in;
        logic              mul_en;
        logic              mul_y;
        logic              coef_head;
        acc_op_t           acc_op;
        logic              rd_head;
        logic              y_we;
        logic              d_we;
        logic              k_clr;
        logic              k_inc;
        jmp_t              jmp;
        logic [STEP_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic    mul_en;
        logic    mul_y;
        logic    coef_head;
        acc_op_t acc_op;
        logic    rd_head;
        logic    rd_zero;
        logic    y_we;
        logic    d_we;
    } dp_ctrl_t;

    // Microprogram store
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        w        = '0;
        w.acc_op = ACC_HOLD;
        w.jmp    = JMP_NEXT;
        unique case (step)
            ST_IDLE: begin
                w.take_in = 1'b1;
                w.k_clr   = 1'b1;
                w.jmp     = JMP_WAIT_IN;
            end
            ST_MUL_B0: begin
                w.mul_en    = 1'b1;
                w.coef_head = 1'b1;
            end
            ST_SUM_D0: begin
                w.acc_op  = ACC_PROD_D;
                w.rd_head = 1'b1;
            end
            ST_OUT: begin
                w.y_we = 1'b1;
                w.jmp  = JMP_WAIT_OUT;
            end
            ST_TAP_BX: begin
                w.mul_en = 1'b1;
                w.acc_op = ACC_LOAD_D;
            end
            ST_TAP_AY: begin
                w.mul_en = 1'b1;
                w.mul_y  = 1'b1;
                w.acc_op = ACC_ADD_P;
            end
            ST_TAP_SUB: begin
                w.acc_op = ACC_SUB_P;
            end
            ST_TAP_WR: begin
                w.d_we   = 1'b1;
                w.k_inc  = 1'b1;
                w.jmp    = JMP_LOOP;
                w.target = ST_TAP_BX;
            end
        endcase
        return w;
    endfunction

    // Round half up, drop the fraction, clamp to the sample range
    function automatic sample_t round_sat_out(input acc_t a);
        acc_t t;
        acc_t s;
        t = a + ROUND_HALF;
        s = t >>> FRAC_BITS;
        if (s > acc_t'(SAMPLE_MAX)) begin
            return SAMPLE_MAX;
        end else if (s < acc_t'(SAMPLE_MIN)) begin
            return SAMPLE_MIN;
        end
        return s[SAMPLE_W-1:0];
    endfunction

    function automatic state_t sat_state(input acc_t a);
        if (a > acc_t'(STATE_MAX)) begin
            return STATE_MAX;
        end else if (a < acc_t'(STATE_MIN)) begin
            return STATE_MIN;
        end
        return a[STATE_W-1:0];
    endfunction

endpackage

// ===== design/iir_filter_transposed_df2.sv =====
// Transposed direct form II IIR filter, order 1 to 3 (capped by MAX_ORDER),
// a0 fixed at one, coefficients signed Q4.20. One 24-bit sample in, one
// filtered sample out, rounded half up and saturated; the 48-bit delay line
// saturates too. A single 24x24 multiplier is shared by all products under
// a small microprogram: four steps to load, form b0*x + d0 and issue the
// result, then four steps for each tap in use. The result waits in an
// output register, so the next sample is taken while it is still pending.
// Any write to filter_order clears the delay line; an order of zero acts as
// order one. Configuration must be written only while the filter is idle;
// the block itself does not enforce this.
module iir_filter_transposed_df2 import iir_tdf2_pkg::*; #(
    parameter int MAX_ORDER = 3
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SAMPLE_W-1:0]   s_tdata,   // [23:0] sample_in
    input  logic                  s_tlast,   // block_end
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [SAMPLE_W-1:0]   m_tdata,   // [23:0] sample_out
    output logic                  m_tlast,   // end_of_block
    // Configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int K_W = $clog2(MAX_ORDER + 1);
    localparam int LIM = (MAX_ORDER < COEF_PAIRS) ? MAX_ORDER : COEF_PAIRS;

    logic [ORDER_W-1:0] order_reg;
    coef_t              coef_b0_reg;
    coef_bank_t         coef_b_reg;
    coef_bank_t         coef_a_reg;
    logic [ORDER_W-1:0] n_eff;
    logic               order_wr;

    logic               last_reg;
    logic               m_tvalid_reg, m_tvalid_next;
    sample_t            m_tdata_reg;
    logic               m_tlast_reg;

    logic               in_ready;
    logic               in_xfer;
    logic               out_free;
    dp_ctrl_t           ctrl;
    logic [K_W-1:0]     k;
    sample_t            y_next;

    // Configuration registers; an order write also clears the delay line
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg   <= ORDER_W'(1);
            coef_b0_reg <= COEF_ONE;
            coef_b_reg  <= '0;
            coef_a_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_ORDER: order_reg     <= cfg_wdata[ORDER_W-1:0];
                REG_B0:    coef_b0_reg   <= cfg_wdata;
                REG_B1:    coef_b_reg[1] <= cfg_wdata;
                REG_B2:    coef_b_reg[2] <= cfg_wdata;
                REG_B3:    coef_b_reg[3] <= cfg_wdata;
                REG_A1:    coef_a_reg[1] <= cfg_wdata;
                REG_A2:    coef_a_reg[2] <= cfg_wdata;
                REG_A3:    coef_a_reg[3] <= cfg_wdata;
            endcase
        end
    end

    assign order_wr = cfg_we && (cfg_index == REG_ORDER);

    // Clamp the order into 1 .. LIM
    always_comb begin
        priority if (order_reg == '0) begin
            n_eff = ORDER_W'(1);
        end else if (order_reg > ORDER_W'(LIM)) begin
            n_eff = ORDER_W'(LIM);
        end else begin
            n_eff = order_reg;
        end
    end

    assign in_xfer  = s_tvalid && in_ready;
    assign out_free = !m_tvalid_reg || m_tready;

    iir_tdf2_seq #(
        .MAX_ORDER (MAX_ORDER),
        .K_W       (K_W)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .n_eff    (n_eff),
        .in_valid (s_tvalid),
        .out_free (out_free),
        .in_ready (in_ready),
        .ctrl     (ctrl),
        .k        (k)
    );

    iir_tdf2_dp #(
        .MAX_ORDER (MAX_ORDER),
        .K_W       (K_W)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .k         (k),
        .in_load   (in_xfer),
        .in_sample (s_tdata),
        .coef_b0   (coef_b0_reg),
        .coef_b    (coef_b_reg),
        .coef_a    (coef_a_reg),
        .d_clear   (order_wr),
        .y_next    (y_next)
    );

    // Hold the block marker alongside the sample in flight
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            last_reg <= s_tlast;
        end
    end

    // Output register: load when the result step advances, drop on transfer
    always_comb begin
        if (ctrl.y_we) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.y_we) begin
            m_tdata_reg <= y_next;
            m_tlast_reg <= last_reg;
        end
    end

    assign s_tready = in_ready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ===== design/iir_tdf2_seq.sv =====
module iir_tdf2_seq import iir_tdf2_pkg::*; #(
    parameter int MAX_ORDER = 3,
    parameter int K_W       = $clog2(MAX_ORDER + 1)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [ORDER_W-1:0] n_eff,
    input  logic               in_valid,
    input  logic               out_free,
    output logic               in_ready,
    output dp_ctrl_t           ctrl,
    output logic [K_W-1:0]     k
);

    logic [STEP_W-1:0] step_reg, step_next;
    logic [K_W-1:0]    k_reg, k_next;
    ucode_t            uw;
    logic [K_W+1:0]    kp1;
    logic              more;
    logic              advance;

    assign uw   = ucode_rom(step_reg);
    assign kp1  = {2'b00, k_reg} + (K_W+2)'(1);
    assign more = kp1 < (K_W+2)'(n_eff);

    always_comb begin
        unique case (uw.jmp)
            JMP_WAIT_IN:  advance = in_valid;
            JMP_WAIT_OUT: advance = out_free;
            default:      advance = 1'b1;
        endcase
    end

    always_comb begin
        step_next = step_reg;
        if (advance) begin
            if (uw.jmp == JMP_LOOP) begin
                step_next = more ? uw.target : ST_IDLE;
            end else begin
                step_next = step_reg + STEP_W'(1);
            end
        end
    end

    always_comb begin
        k_next = k_reg;
        if (advance && uw.k_clr) begin
            k_next = '0;
        end else if (advance && uw.k_inc) begin
            k_next = k_reg + K_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= ST_IDLE;
            k_reg    <= '0;
        end else begin
            step_reg <= step_next;
            k_reg    <= k_next;
        end
    end

    // Gate every write with advance so a stalled step changes nothing
    always_comb begin
        ctrl.mul_en    = uw.mul_en && advance;
        ctrl.mul_y     = uw.mul_y;
        ctrl.coef_head = uw.coef_head;
        ctrl.acc_op    = advance ? uw.acc_op : ACC_HOLD;
        ctrl.rd_head   = uw.rd_head;
        ctrl.rd_zero   = !more;
        ctrl.y_we      = uw.y_we && advance;
        ctrl.d_we      = uw.d_we && advance;
    end

    assign in_ready = uw.take_in;
    assign k        = k_reg;

endmodule

// ===== design/iir_tdf2_dp.sv =====
module iir_tdf2_dp import iir_tdf2_pkg::*; #(
    parameter int MAX_ORDER = 3,
    parameter int K_W       = $clog2(MAX_ORDER + 1)
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  dp_ctrl_t       ctrl,
    input  logic [K_W-1:0] k,
    input  logic           in_load,
    input  sample_t        in_sample,
    input  coef_t          coef_b0,
    input  coef_bank_t     coef_b,
    input  coef_bank_t     coef_a,
    input  logic           d_clear,
    output sample_t        y_next
);

    localparam int IDX_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

    sample_t        x_reg;
    sample_t        y_reg;
    state_t         prod_reg;
    acc_t           acc_reg, acc_next;
    state_t         delay_reg [MAX_ORDER];
    logic [K_W+1:0] kp1;
    logic [1:0]     coef_idx;
    sample_t        op_sel;
    coef_t          coef_sel;
    state_t         prod_next;
    state_t         d_rd;

    assign kp1      = {2'b00, k} + (K_W+2)'(1);
    assign coef_idx = kp1[1:0];

    always_comb begin
        op_sel = ctrl.mul_y ? y_reg : x_reg;
        if (ctrl.coef_head) begin
            coef_sel = coef_b0;
        end else if (ctrl.mul_y) begin
            coef_sel = $signed(coef_a[coef_idx]);
        end else begin
            coef_sel = $signed(coef_b[coef_idx]);
        end
        prod_next = state_t'(op_sel) * state_t'(coef_sel);
    end

    // Past the last tap the next entry reads as zero
    always_comb begin
        if (ctrl.rd_head) begin
            d_rd = delay_reg[0];
        end else if (ctrl.rd_zero) begin
            d_rd = '0;
        end else begin
            d_rd = delay_reg[kp1[IDX_W-1:0]];
        end
    end

    always_comb begin
        unique case (ctrl.acc_op)
            ACC_LOAD_D: acc_next = acc_t'(d_rd);
            ACC_PROD_D: acc_next = acc_t'(prod_reg) + acc_t'(d_rd);
            ACC_ADD_P:  acc_next = acc_reg + acc_t'(prod_reg);
            ACC_SUB_P:  acc_next = acc_reg - acc_t'(prod_reg);
            default:    acc_next = acc_reg;
        endcase
    end

    assign y_next = round_sat_out(acc_reg);

    always_ff @(posedge aclk) begin
        if (in_load) begin
            x_reg <= in_sample;
        end
        if (ctrl.mul_en) begin
            prod_reg <= prod_next;
        end
        if (ctrl.y_we) begin
            y_reg <= y_next;
        end
        acc_reg <= acc_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || d_clear) begin
            for (int i = 0; i < MAX_ORDER; i++) begin
                delay_reg[i] <= '0;
            end
        end else if (ctrl.d_we) begin
            delay_reg[k[IDX_W-1:0]] <= sat_state(acc_reg);
        end
    end

endmodule

// ===== design/iir_tdf2_chk.sv =====
`include "iir_filter_transposed_df2_defines.svh"

module iir_tdf2_chk import iir_tdf2_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [SAMPLE_W-1:0] m_tdata,
    input logic                m_tlast
);

    logic [1:0] pend_reg, pend_next;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;

    // Samples accepted whose results are not yet transferred
    always_comb begin
        unique case ({in_xfer, out_xfer})
            2'b10:   pend_next = pend_reg + 2'd1;
            2'b01:   pend_next = pend_reg - 2'd1;
            default: pend_next = pend_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    `IIR_TDF2_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")
    `IIR_TDF2_ASSERT_RESET(a_reset_idle, aclk, aresetn, !m_tvalid, "result valid after reset")
    `IIR_TDF2_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, in_xfer, !s_tready, "input taken while busy")
    `IIR_TDF2_ASSERT_NOW(a_no_extra_out, aclk, aresetn, out_xfer, pend_reg != 2'd0, "result without sample")
    `IIR_TDF2_ASSERT_NOW(a_pend_bound, aclk, aresetn, 1'b1, pend_reg != 2'd3, "too many samples in flight")

endmodule

bind iir_filter_transposed_df2 iir_tdf2_chk u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== tb/tb_iir_filter_transposed_df2.sv =====
module tb_iir_filter_transposed_df2;
    import iir_tdf2_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     TAPS         = 3;
    localparam int     CLK_HALF     = 6;
    localparam int     HOLD_CYCLES  = 200;   // long receiver hold-off
    localparam int     DRAIN_LIMIT  = 5000;  // cycles to wait for outstanding results
    localparam int     SETTLE       = 24;    // tap updates run on after the result
    localparam int     PHASES       = 10;
    localparam int     PHASE_ITEMS  = 55;
    localparam longint ROUND_BIAS   = 64'sd1 <<< (FRAC_BITS - 1);
    localparam coef_t  COEF_MAX     = 24'sh7FFFFF;
    localparam coef_t  COEF_MIN     = 24'sh800000;

    typedef struct {
        sample_t smp;
        logic    eob;
    } filt_out_t;

    // DUT ports; every input starts at a known value
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [SAMPLE_W-1:0]   s_tdata   = '0;    // [23:0] sample_in
    logic                  s_tlast   = 1'b0;  // block_end
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [SAMPLE_W-1:0]   m_tdata;           // [23:0] sample_out
    logic                  m_tlast;           // end_of_block
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Filter predictor: its own copy of the registers and the delay line
    logic [ORDER_W-1:0] order_set;
    coef_t              tap_b [TAPS+1];
    coef_t              tap_a [TAPS+1];
    state_t             dly   [TAPS];

    filt_out_t filtered_q [$];   // filtered samples still to come out

    int   fail_count    = 0;
    int   samples_sent  = 0;
    int   results_seen  = 0;
    int   settings_used = 0;
    int   hold_req      = 0;     // bumped to ask the receiver for a long hold-off
    bit   tx_no_idle    = 1'b0;
    bit   rx_no_idle    = 1'b0;

    iir_filter_transposed_df2 #(
        .MAX_ORDER (TAPS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // Clamp a tap sum to the 48-bit delay range
    function automatic state_t clamp_state(input longint v);
        if (v > longint'(STATE_MAX)) begin
            return STATE_MAX;
        end else if (v < longint'(STATE_MIN)) begin
            return STATE_MIN;
        end
        return state_t'(v);
    endfunction

    // One transposed DF2 step: form the output from b0*x + d0, then shift the
    // delay line along, feeding back the rounded and saturated output
    function automatic sample_t filter_step(input sample_t x);
        int     n;
        longint xl;
        longint yl;
        longint acc;
        n = (order_set == 0) ? 1 : int'(order_set);
        if (n > TAPS) begin
            n = TAPS;
        end
        xl  = longint'(x);
        acc = longint'(tap_b[0]) * xl + longint'(dly[0]) + ROUND_BIAS;
        yl  = acc >>> FRAC_BITS;
        if (yl > longint'(SAMPLE_MAX)) begin
            yl = longint'(SAMPLE_MAX);
        end else if (yl < longint'(SAMPLE_MIN)) begin
            yl = longint'(SAMPLE_MIN);
        end
        for (int j = 0; j < n - 1; j++) begin
            dly[j] = clamp_state(longint'(tap_b[j+1]) * xl - longint'(tap_a[j+1]) * yl
                                 + longint'(dly[j+1]));
        end
        dly[n-1] = clamp_state(longint'(tap_b[n]) * xl - longint'(tap_a[n]) * yl);
        return sample_t'(yl);
    endfunction

    function automatic coef_t rand_coef(input int span);
        if (span == 0) begin
            return coef_t'($urandom);
        end
        return coef_t'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic coef_t pick_extreme();
        case ($urandom_range(0, 3))
            0:       return COEF_MAX;
            1:       return COEF_MIN;
            2:       return COEF_ONE;
            default: return coef_t'(0);
        endcase
    endfunction

    function automatic sample_t rand_sample();
        case ($urandom_range(0, 9))
            6, 7:    return sample_t'(int'($urandom_range(0, 8192)) - 4096);
            8:       return ($urandom_range(0, 1) != 0) ? SAMPLE_MAX : SAMPLE_MIN;
            9:       return sample_t'(0);
            default: return sample_t'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    // Write one register and mirror it in the predictor. Leaves cfg_we high so
    // that back-to-back writes need no second assignment in the same step.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_ORDER: begin
                order_set = val[ORDER_W-1:0];
                foreach (dly[k]) begin
                    dly[k] = '0;
                end
            end
            REG_B0:  tap_b[0] = coef_t'(val);
            REG_B1:  tap_b[1] = coef_t'(val);
            REG_B2:  tap_b[2] = coef_t'(val);
            REG_B3:  tap_b[3] = coef_t'(val);
            REG_A1:  tap_a[1] = coef_t'(val);
            REG_A2:  tap_a[2] = coef_t'(val);
            REG_A3:  tap_a[3] = coef_t'(val);
            default: ;
        endcase
    endtask

    task automatic load_filter(input int ord,
                               input coef_t b0, input coef_t b1, input coef_t b2,
                               input coef_t b3, input coef_t a1, input coef_t a2,
                               input coef_t a3);
        cfg_write(REG_ORDER, CFG_DATA_W'(ord));
        cfg_write(REG_B0, b0);
        cfg_write(REG_B1, b1);
        cfg_write(REG_B2, b2);
        cfg_write(REG_B3, b3);
        cfg_write(REG_A1, a1);
        cfg_write(REG_A2, a2);
        cfg_write(REG_A3, a3);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Rewrite the order alone; even the same value empties the delay line
    task automatic write_order(input int ord);
        cfg_write(REG_ORDER, CFG_DATA_W'(ord));
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Offer one sample after a random gap and hold it until the transfer.
    // tvalid is left high afterwards so a zero gap keeps the stream dense.
    task automatic send_sample(input sample_t smp, input logic eob);
        int        gap;
        filt_out_t want;
        gap = tx_no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= eob;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        want.smp = filter_step(smp);
        want.eob = eob;
        filtered_q.push_back(want);
        samples_sent++;
    endtask

    // Stop offering, wait for every outstanding result, then let the tap
    // updates that follow the last result finish before anything else
    task automatic wait_all_results();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (filtered_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (filtered_q.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", filtered_q.size()));
            filtered_q.delete();
        end
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Reset defaults give unity gain at order one: output equals input
    task automatic test_passthrough();
        send_sample(sample_t'(0), 1'b0);
        send_sample(SAMPLE_MAX, 1'b1);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(sample_t'(1), 1'b1);
        send_sample(sample_t'(-1), 1'b0);
        send_sample(sample_t'(24'h555555), 1'b0);
        send_sample(sample_t'(24'hAAAAAA), 1'b1);
        wait_all_results();
    endtask

    // Order handling: a rewrite of the same order clears the state, order
    // zero behaves as order one, and order three uses every tap
    task automatic test_order_cases();
        load_filter(2, 24'sh080000, 24'sh040000, 24'sh020000, 24'sh010000,
                    24'sh0C0000, 24'shF80000, 24'sh020000);
        send_sample(sample_t'(24'sh200000), 1'b0);
        send_sample(sample_t'(-24'sh100000), 1'b1);
        wait_all_results();
        write_order(2);
        send_sample(sample_t'(24'sh200000), 1'b0);
        send_sample(sample_t'(24'sh000123), 1'b1);
        wait_all_results();
        write_order(0);
        send_sample(sample_t'(24'sh300000), 1'b0);
        send_sample(sample_t'(-24'sh000777), 1'b1);
        wait_all_results();
        write_order(3);
        send_sample(sample_t'(24'sh400000), 1'b0);
        send_sample(sample_t'(-24'sh400000), 1'b0);
        send_sample(sample_t'(24'sh012345), 1'b1);
        wait_all_results();
    endtask

    // Extreme gains drive both the delay line and the output into the rails
    task automatic test_saturation();
        load_filter(3, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX,
                    COEF_MIN, COEF_MIN, COEF_MIN);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(sample_t'(0), 1'b0);
        send_sample(sample_t'(1), 1'b1);
        wait_all_results();
    endtask

    // Random phases: half with tame coefficients so the recursion runs for a
    // while, the rest fully random or from the extremes
    task automatic test_random_phases();
        int    ord;
        int    style;
        coef_t cs [7];
        for (int ph = 0; ph < PHASES; ph++) begin
            style = (ph == 3 || ph == 7) ? 2 : ((ph % 4 == 1) ? 1 : 0);
            ord   = (ph < 4) ? ph : $urandom_range(0, 3);
            for (int k = 0; k < 7; k++) begin
                case (style)
                    0:       cs[k] = (k < 4) ? rand_coef(1 << 19) : rand_coef(1 << 18);
                    1:       cs[k] = rand_coef(0);
                    default: cs[k] = pick_extreme();
                endcase
            end
            load_filter(ord, cs[0], cs[1], cs[2], cs[3], cs[4], cs[5], cs[6]);
            // every third phase runs with no idling on either side
            tx_no_idle  = (ph % 3 == 2);
            rx_no_idle <= (ph % 3 == 2);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                send_sample(rand_sample(), $urandom_range(0, 7) == 0);
            end
            wait_all_results();
        end
        tx_no_idle  = 1'b0;
        rx_no_idle <= 1'b0;
    endtask

    // Hold the receiver off for a long stretch while samples keep coming,
    // so the output register fills and the input stalls
    task automatic test_backpressure();
        load_filter(3, rand_coef(1 << 19), rand_coef(1 << 19), rand_coef(1 << 19),
                    rand_coef(1 << 19), rand_coef(1 << 18), rand_coef(1 << 18),
                    rand_coef(1 << 18));
        tx_no_idle = 1'b1;
        hold_req  <= hold_req + 1;
        for (int i = 0; i < 30; i++) begin
            send_sample(rand_sample(), i % 8 == 7);
        end
        tx_no_idle = 1'b0;
        wait_all_results();
    endtask

    // Pause the sender until the stream is empty, then carry on with the
    // same state in the delay line
    task automatic test_pause_resume();
        for (int i = 0; i < 12; i++) begin
            send_sample(rand_sample(), i == 11);
        end
        s_tvalid <= 1'b0;
        while (filtered_q.size() != 0) @(posedge aclk);
        for (int i = 0; i < 12; i++) begin
            send_sample(rand_sample(), i == 11);
        end
        wait_all_results();
    endtask

    // Receiver: a random stall after each transfer, plus the long hold-off
    // on request, all counted in cycles here
    initial begin
        int rx_wait;
        int rx_hold;
        int hold_seen;
        rx_wait   = 0;
        rx_hold   = 0;
        hold_seen = 0;
        forever begin
            @(posedge aclk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                rx_hold   = HOLD_CYCLES;
            end
            if (m_tvalid && m_tready) begin
                rx_wait = rx_no_idle ? 0 : $urandom_range(0, 4);
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Compare each result transfer with the oldest expected sample
    always @(posedge aclk) begin
        filt_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (filtered_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result %06h", m_tdata));
            end else begin
                want = filtered_q.pop_front();
                if (m_tdata !== want.smp) begin
                    report_mismatch($sformatf("result %0d: sample_out %06h, want %06h",
                                              results_seen, m_tdata, want.smp));
                end
                if (m_tlast !== want.eob) begin
                    report_mismatch($sformatf("result %0d: end_of_block %b, want %b",
                                              results_seen, m_tlast, want.eob));
                end
            end
        end
    end

    initial begin
        // predictor starts from the reset settings
        order_set = ORDER_W'(1);
        foreach (tap_b[k]) begin
            tap_b[k] = '0;
            tap_a[k] = '0;
        end
        tap_b[0] = COEF_ONE;
        foreach (dly[k]) begin
            dly[k] = '0;
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_passthrough();
        test_order_cases();
        test_saturation();
        test_random_phases();
        test_backpressure();
        test_pause_resume();

        wait_all_results();
        $display("Ran %0d samples through %0d filter settings, %0d results checked.",
                 samples_sent, settings_used, results_seen);
        $display("Orders 0 to 3, rail and random coefficients, saturation and stalls.");
        if (fail_count == 0) begin
            $display("tb_iir_filter_transposed_df2: PASS");
        end else begin
            $display("tb_iir_filter_transposed_df2: FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin
        #3ms;
        $display("tb_iir_filter_transposed_df2: FAIL");
        $finish;
    end

endmodule
